// ===== design/dfm_pkg.sv =====
// Shared types and constants for the duplicate feature marker.
// Used by dfm_front, dfm_back and the top module; depends on nothing.
package dfm_pkg;

   localparam int MZ_W    = 32;
   localparam int RT_W    = 32;
   localparam int MISS_W  = 16;
   localparam int ABUND_W = 32;
   localparam int IDX_W   = 10;
   localparam int CSR_W   = 32;

   // Command field codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Classified operations handed from front to back
   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_LOAD_LAST = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;

   // Configuration register indexes
   localparam logic CSR_MZ_TOL = 1'b0;
   localparam logic CSR_RT_TOL = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [MZ_W-1:0]      feature_mz;
      logic [RT_W-1:0]      feature_rt;
      logic [MISS_W-1:0]    feature_missing;
      logic [ABUND_W-1:0]   feature_abundance;
      logic                 last_feature;
      logic [IDX_W-1:0]     read_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] flag_index;
      logic             is_duplicate;
      logic             index_valid;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [MZ_W-1:0]      mz;
      logic [RT_W-1:0]      rt;
      logic [MISS_W-1:0]    missing;
      logic [ABUND_W-1:0]   abundance;
      logic [IDX_W-1:0]     index;
   } op_type;

   typedef struct packed {
      logic [MZ_W-1:0] mz_tolerance;
      logic [RT_W-1:0] rt_tolerance;
   } cfg_type;

endpackage

// ===== design/dfm_fifo.sv =====
// Small synchronous FIFO used between front and back and on the result side.
// No package dependencies.
module dfm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/dfm_front.sv =====
// Front end: accepts request transactions, classifies them into operations
// and queues them for the back end. Depends on dfm_pkg and dfm_fifo.
module dfm_front
   import dfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    op_pop,
   output op_type  op_data,
   output logic    op_empty
);

   op_type                 op_cls;
   logic [$bits(op_type)-1:0] op_vec;

   always_comb begin
      op_cls.mz        = req_data.feature_mz;
      op_cls.rt        = req_data.feature_rt;
      op_cls.missing   = req_data.feature_missing;
      op_cls.abundance = req_data.feature_abundance;
      op_cls.index     = req_data.read_index;
      if (req_data.cmd == CMD_READ) begin
         op_cls.op = OP_READ;
      end else if (req_data.last_feature) begin
         op_cls.op = OP_LOAD_LAST;
      end else begin
         op_cls.op = OP_LOAD;
      end
   end

   dfm_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (4)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (op_cls),
      .full      (req_full),
      .pop       (op_pop),
      .pop_data  (op_vec),
      .empty     (op_empty)
   );

   assign op_data = op_vec;

endmodule

// ===== design/dfm_back.sv =====
// Back end: feature stores, flag memory and the pairwise marking sequencer.
// Depends on dfm_pkg.
module dfm_back
   import dfm_pkg::*;
#(
   parameter int MAX_FEATURES = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  op_type  op_data,
   input  logic    op_empty,
   output logic    op_pop,
   output logic    rsp_push,
   output rsp_type rsp_item,
   input  logic    rsp_full
);

   localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW = $clog2(MAX_FEATURES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_FEATURES);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_RD_WAIT    = 3'd1;
   localparam logic [2:0] S_CLEAR      = 3'd2;
   localparam logic [2:0] S_OUTER      = 3'd3;
   localparam logic [2:0] S_OUTER_WAIT = 3'd4;
   localparam logic [2:0] S_INNER      = 3'd5;
   localparam logic [2:0] S_INNER_WAIT = 3'd6;

   // Feature stores and flags
   logic [MZ_W-1:0]    mz_mem    [MAX_FEATURES];
   logic [RT_W-1:0]    rt_mem    [MAX_FEATURES];
   logic [MISS_W-1:0]  miss_mem  [MAX_FEATURES];
   logic [ABUND_W-1:0] abund_mem [MAX_FEATURES];
   logic               flag_mem  [MAX_FEATURES];

   logic [MZ_W-1:0]    mz_rd_ff;
   logic [RT_W-1:0]    rt_rd_ff;
   logic [MISS_W-1:0]  miss_rd_ff;
   logic [ABUND_W-1:0] abund_rd_ff;
   logic               flag_rd_ff;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               closed_ff, closed_in;
   logic [CW-1:0]      a_ff, a_in;
   logic [CW-1:0]      b_ff, b_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MZ_W-1:0]    mz_a_ff, mz_a_in;
   logic [RT_W-1:0]    rt_a_ff, rt_a_in;
   logic [MISS_W-1:0]  miss_a_ff, miss_a_in;
   logic [ABUND_W-1:0] abund_a_ff, abund_a_in;

   logic               st_we;
   logic [AW-1:0]      st_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               fl_we;
   logic [AW-1:0]      fl_addr;
   logic               fl_wdata;

   logic [CW-1:0]      base_count;
   logic [CW-1:0]      a_plus;
   logic [CW-1:0]      b_plus;
   logic [MZ_W:0]      mz_diff;
   logic               mz_stop;
   logic [RT_W-1:0]    rt_gap;
   logic               mark_a;

   assign base_count = closed_ff ? '0 : count_ff;
   assign a_plus     = a_ff + 1'b1;
   assign b_plus     = b_ff + 1'b1;

   // Pair tests: m/z window end (signed, so unsorted input never stops), RT gap,
   // and which of the pair gets flagged.
   assign mz_diff = {1'b0, mz_rd_ff} - {1'b0, mz_a_ff};
   assign mz_stop = !mz_diff[MZ_W] && (mz_diff[MZ_W-1:0] > cfg.mz_tolerance);
   assign rt_gap  = (rt_a_ff > rt_rd_ff) ? rt_a_ff - rt_rd_ff : rt_rd_ff - rt_a_ff;
   assign mark_a  = (miss_a_ff > miss_rd_ff) ||
                    ((miss_a_ff == miss_rd_ff) && (abund_a_ff < abund_rd_ff));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      closed_in  = closed_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      idx_in     = idx_ff;
      mz_a_in    = mz_a_ff;
      rt_a_in    = rt_a_ff;
      miss_a_in  = miss_a_ff;
      abund_a_in = abund_a_ff;
      op_pop     = 1'b0;
      st_we      = 1'b0;
      st_addr    = base_count[AW-1:0];
      rd_en      = 1'b0;
      rd_addr    = '0;
      fl_we      = 1'b0;
      fl_addr    = '0;
      fl_wdata   = 1'b0;
      rsp_push   = 1'b0;

      rsp_item.flag_index   = idx_ff;
      rsp_item.index_valid  = (32'(idx_ff) < 32'(count_ff));
      rsp_item.is_duplicate = rsp_item.index_valid && closed_ff && flag_rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!op_empty) begin
               op_pop = 1'b1;
               if (op_data.op == OP_READ) begin
                  idx_in   = op_data.index;
                  rd_en    = 1'b1;
                  rd_addr  = AW'(op_data.index);
                  state_in = S_RD_WAIT;
               end else begin
                  // A load after a closed set opens a new one.
                  closed_in = 1'b0;
                  count_in  = base_count;
                  if (base_count < FULL_COUNT) begin
                     st_we    = 1'b1;
                     count_in = base_count + 1'b1;
                  end
                  if (op_data.op == OP_LOAD_LAST) begin
                     closed_in = 1'b1;
                     b_in      = '0;
                     state_in  = S_CLEAR;
                  end
               end
            end
         end
         S_RD_WAIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (b_ff < count_ff) begin
               fl_we   = 1'b1;
               fl_addr = b_ff[AW-1:0];
               b_in    = b_plus;
            end else begin
               a_in     = '0;
               state_in = S_OUTER;
            end
         end
         S_OUTER: begin
            if (a_plus >= count_ff) begin
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = a_ff[AW-1:0];
               state_in = S_OUTER_WAIT;
            end
         end
         S_OUTER_WAIT: begin
            mz_a_in    = mz_rd_ff;
            rt_a_in    = rt_rd_ff;
            miss_a_in  = miss_rd_ff;
            abund_a_in = abund_rd_ff;
            if (flag_rd_ff) begin
               a_in     = a_plus;
               state_in = S_OUTER;
            end else begin
               b_in     = a_plus;
               state_in = S_INNER;
            end
         end
         S_INNER: begin
            if (b_ff >= count_ff) begin
               a_in     = a_plus;
               state_in = S_OUTER;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = b_ff[AW-1:0];
               state_in = S_INNER_WAIT;
            end
         end
         S_INNER_WAIT: begin
            if (mz_stop) begin
               a_in     = a_plus;
               state_in = S_OUTER;
            end else if (flag_rd_ff || (rt_gap > cfg.rt_tolerance)) begin
               b_in     = b_plus;
               state_in = S_INNER;
            end else if (mark_a) begin
               // Once i is flagged every later pair is skipped: move on.
               fl_we    = 1'b1;
               fl_addr  = a_ff[AW-1:0];
               fl_wdata = 1'b1;
               a_in     = a_plus;
               state_in = S_OUTER;
            end else begin
               fl_we    = 1'b1;
               fl_addr  = b_ff[AW-1:0];
               fl_wdata = 1'b1;
               b_in     = b_plus;
               state_in = S_INNER;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         closed_ff <= 1'b0;
         a_ff      <= '0;
         b_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      mz_a_ff    <= mz_a_in;
      rt_a_ff    <= rt_a_in;
      miss_a_ff  <= miss_a_in;
      abund_a_ff <= abund_a_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         mz_mem[st_addr]    <= op_data.mz;
         rt_mem[st_addr]    <= op_data.rt;
         miss_mem[st_addr]  <= op_data.missing;
         abund_mem[st_addr] <= op_data.abundance;
      end
      if (rd_en) begin
         mz_rd_ff    <= mz_mem[rd_addr];
         rt_rd_ff    <= rt_mem[rd_addr];
         miss_rd_ff  <= miss_mem[rd_addr];
         abund_rd_ff <= abund_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         flag_mem[fl_addr] <= fl_wdata;
      end
      if (rd_en) begin
         flag_rd_ff <= flag_mem[rd_addr];
      end
   end

endmodule

// ===== design/duplicate_feature_marker.sv =====
// Duplicate feature marker: a load is stored in the back end when popped from the op queue;
// a read passes the op queue, the back end's read and wait states and the result queue.
// A pass over N features (started by last_feature) clears the flags, then scans the later
// features against each unflagged outer feature until the m/z window ends or they run out;
// all reads share the single read port of the feature memories.
// Reset (synchronous, active high) empties queues, count and set state; tolerances go to 1000.
module duplicate_feature_marker
   import dfm_pkg::*;
#(
   parameter int MAX_FEATURES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   // request queue side
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   // result queue side
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   // configuration writes
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cfg_type                     cfg_ff, cfg_in;
   op_type                      op_data;
   logic                        op_empty;
   logic                        op_pop;
   logic                        rsp_push;
   rsp_type                     rsp_item;
   logic                        rsp_full;
   logic [$bits(rsp_type)-1:0]  rsp_vec;

   // Configuration registers: plain writes, no read-back.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MZ_TOL: cfg_in.mz_tolerance = csr_wdata;
            CSR_RT_TOL: cfg_in.rt_tolerance = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mz_tolerance <= MZ_W'(1000);
         cfg_ff.rt_tolerance <= RT_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accepts and classifies each request transaction into the op queue.
   dfm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_pop   (op_pop),
      .op_data  (op_data),
      .op_empty (op_empty)
   );

   // Back: stores features, runs the marking pass and answers flag reads.
   dfm_back #(
      .MAX_FEATURES (MAX_FEATURES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_data  (op_data),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .rsp_full (rsp_full)
   );

   // Result queue decouples the back end from a stalled consumer.
   dfm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_vec;

endmodule
